### sv/dss_pkg.sv
// Shared types, constants and groove tables of the drum step sequencer.
`timescale 1ns / 1ps

package dss_pkg;

    // Default geometry
    localparam int DEF_SLOTS = 8;
    localparam int DEF_STEPS = 32;

    // Field widths
    localparam int MEL_W   = 4;   // stored melodic sound id
    localparam int SOUND_W = 5;   // emitted sound id
    localparam int STEP_W  = 5;   // emitted step index
    localparam int OFF_W   = 5;   // insert offset
    localparam int GRV_W   = 6;   // step number fed to the groove tables

    // Fixed sound ids
    localparam logic [SOUND_W-1:0] KICK_ID  = 5'd15;
    localparam logic [SOUND_W-1:0] SNARE_ID = 5'd16;

    // Request kinds
    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_WRITE,
        ST_SCAN
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic in_ready;    // input word may be taken
        logic rd_issue;    // read the target row
        logic row_load;    // capture the row read back
        logic wr_insert;   // write the pushed row back
        logic slot_inc;    // next slot of the scan
        logic emit;        // load the output register
        logic finish;      // end of tick: erase, advance pointer
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_insert;
        logic cur_nz;      // slot under scan holds a sound
        logic slot_end;    // scan is on the top slot
        logic out_free;    // output register can take a word
    } dp_sts_t;

    // Kick groove in slot 0
    function automatic logic has_kick(input logic [GRV_W-1:0] step);
        logic hit;
        unique case (step) inside
            6'd0, 6'd2, 6'd8, 6'd10, 6'd16, 6'd21, 6'd23, 6'd24, 6'd26: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Snare groove in slot 1
    function automatic logic has_snare(input logic [GRV_W-1:0] step);
        logic hit;
        unique case (step) inside
            6'd4, 6'd12, 6'd20, 6'd28: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

### sv/drum_step_sequencer_unit.sv
// Top level of the drum step sequencer: controller, datapath and checks.
//
//  channel  | dir | handshake            | content
//  ---------+-----+----------------------+---------------------------------------
//  s_       | in  | s_tvalid / s_tready  | tick or insert request
//  m_       | out | m_tvalid / m_tready  | one sound per word, m_tlast ends a step
//  cfg_     | in  | cfg_valid/cfg_ready  | erase_enable
//
// An insert passes through accept, row read, row capture and row write.
// A tick passes through accept, row read, row capture, then a scan of the
// slots one after another; a slot that holds a sound waits while the output
// register is held by m_tready low. The single read port of the pattern RAM
// and the slot-by-slot scan set this order of steps. Reset clears the
// pointer and the per-row valid bits at once; there is no clearing pass.
`timescale 1ns / 1ps

module drum_step_sequencer_unit
    import dss_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS,
    parameter int STEPS = DEF_STEPS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request: [4:0] insert_offset, [8:5] sound_in, rest zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [0:0]  s_tuser,   // [0] req_type
    // result: [4:0] sound_id, [9:5] step_index, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast,   // last_of_step
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data   // [0] erase_enable
);

    ctrl_cmd_t          cmd;
    dp_sts_t            sts;
    logic [SOUND_W-1:0] out_sound;
    logic [STEP_W-1:0]  out_step;

    dss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    dss_datapath #(
        .SLOTS (SLOTS),
        .STEPS (STEPS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tvalid  (s_tvalid),
        .in_req    (s_tuser[0]),
        .in_off    (s_tdata[4:0]),
        .in_sound  (s_tdata[8:5]),
        .cfg_wr    (cfg_valid & cfg_ready),
        .cfg_bit   (cfg_data[0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sound (out_sound),
        .out_step  (out_step),
        .out_last  (m_tlast)
    );

    assign s_tready  = cmd.in_ready;
    assign cfg_ready = 1'b1;
    assign m_tdata   = {6'b0, out_step, out_sound};

    // Checks

    // one request at a time: ready drops after a word is taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in work");

    // the scan never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("output register overwritten");

    // only nonzero slots are emitted
    a_emit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.cur_nz)
        else $error("silent slot emitted");

    // no result is produced while the block waits for a request
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |=> !($past(cmd.emit)))
        else $error("result emitted while idle");

endmodule

### sv/dss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module dss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/dss_ctrl.sv
// Controller state machine of the drum step sequencer.
`timescale 1ns / 1ps

module dss_ctrl
    import dss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  dp_sts_t    sts,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.row_load = 1'b1;
                state_next   = sts.is_insert ? ST_WRITE : ST_SCAN;
            end
            ST_WRITE: begin
                cmd.wr_insert = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_SCAN: begin
                // a silent slot passes at once, a sound waits for the output
                if (!sts.cur_nz || sts.out_free) begin
                    cmd.emit = sts.cur_nz;
                    if (sts.slot_end) begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.slot_inc = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/dss_datapath.sv
// Datapath: pattern memory, play pointer, slot scan and output register.
`timescale 1ns / 1ps

module dss_datapath
    import dss_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS,
    parameter int STEPS = DEF_STEPS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctrl_cmd_t          cmd,
    output dp_sts_t            sts,
    // input word
    input  logic               s_tvalid,
    input  logic               in_req,
    input  logic [OFF_W-1:0]   in_off,
    input  logic [MEL_W-1:0]   in_sound,
    // configuration
    input  logic               cfg_wr,
    input  logic               cfg_bit,
    // result word
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SOUND_W-1:0] out_sound,
    output logic [STEP_W-1:0]  out_step,
    output logic               out_last
);

    localparam int PTR_W  = $clog2(STEPS);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ROW_W  = (SLOTS - 2) * MEL_W;
    localparam int OFF_N  = 1 << OFF_W;

    // Captured request
    logic               req_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [MEL_W-1:0]   snd_reg;
    logic               erase_reg;

    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [PTR_W-1:0]   addr_reg, addr;
    logic [STEPS-1:0]   valid_reg;
    logic [ROW_W-1:0]   row_reg, rd_row;
    logic [SLOT_W-1:0]  slot_reg;

    logic               out_valid_reg;
    logic [SOUND_W-1:0] out_sound_reg;
    logic [STEP_W-1:0]  out_step_reg;
    logic               out_last_reg;

    logic [PTR_W-1:0]   off_mod_lut [OFF_N];
    logic [PTR_W-1:0]   off_mod;
    logic [PTR_W:0]     sum;
    logic [SOUND_W-1:0] slot_val [SLOTS];
    logic [SLOTS-1:0]   nz;
    logic [SLOTS-1:0]   higher;
    logic               kick_on, snare_on, cur_last;

    // Offset reduced modulo the step count
    for (genvar g = 0; g < OFF_N; g++) begin : g_off_mod
        assign off_mod_lut[g] = PTR_W'(g % STEPS);
    end
    assign off_mod = off_mod_lut[off_reg];

    // Target row: play pointer for a tick, pointer plus offset for an insert
    always_comb begin
        sum = {1'b0, ptr_reg} + {1'b0, off_mod};
        if (sum >= (PTR_W + 1)'(STEPS)) begin
            sum = sum - (PTR_W + 1)'(STEPS);
        end
        addr = (req_reg == REQ_INSERT) ? sum[PTR_W-1:0] : ptr_reg;
    end

    assign ptr_next = (ptr_reg == PTR_W'(STEPS - 1)) ? '0 : ptr_reg + PTR_W'(1);

    // Melodic slots of one step as one row, slot 2 in the low bits
    dss_ram #(
        .WIDTH (ROW_W),
        .DEPTH (STEPS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_insert),
        .wr_addr (addr_reg),
        .wr_data (ROW_W'({row_reg, snd_reg})),
        .rd_en   (cmd.rd_issue),
        .rd_addr (addr),
        .rd_data (rd_row)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            valid_reg <= '0;
            erase_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                erase_reg <= cfg_bit;
            end
            if (cmd.wr_insert) begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (cmd.finish) begin
                ptr_reg <= ptr_next;
                if (erase_reg) begin
                    valid_reg[addr_reg] <= 1'b0;
                end
            end
        end
    end

    // Request, row and scan registers
    always_ff @(posedge aclk) begin
        if (cmd.in_ready && s_tvalid) begin
            req_reg <= in_req;
            off_reg <= in_off;
            snd_reg <= in_sound;
        end
        if (cmd.rd_issue) begin
            addr_reg <= addr;
        end
        if (cmd.row_load) begin
            row_reg  <= valid_reg[addr_reg] ? rd_row : '0;
            slot_reg <= '0;
        end else if (cmd.slot_inc) begin
            slot_reg <= slot_reg + SLOT_W'(1);
        end
    end

    // Sounds of the step under scan
    assign kick_on  = has_kick(GRV_W'(addr_reg));
    assign snare_on = has_snare(GRV_W'(addr_reg));
    assign slot_val[0] = kick_on  ? KICK_ID  : '0;
    assign slot_val[1] = snare_on ? SNARE_ID : '0;
    for (genvar s = 2; s < SLOTS; s++) begin : g_slot
        assign slot_val[s] = SOUND_W'(row_reg[(s - 2) * MEL_W +: MEL_W]);
    end
    for (genvar s = 0; s < SLOTS; s++) begin : g_nz
        assign nz[s] = |slot_val[s];
    end

    // Last sound: no nonzero slot above the current one
    assign higher   = (nz >> slot_reg) >> 1;
    assign cur_last = ~|higher;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_sound_reg <= slot_val[slot_reg];
            out_step_reg  <= STEP_W'(addr_reg);
            out_last_reg  <= cur_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sound = out_sound_reg;
    assign out_step  = out_step_reg;
    assign out_last  = out_last_reg;

    // Status
    assign sts.is_insert = (req_reg == REQ_INSERT);
    assign sts.cur_nz    = nz[slot_reg];
    assign sts.slot_end  = (slot_reg == SLOT_W'(SLOTS - 1));
    assign sts.out_free  = !out_valid_reg || out_ready;

endmodule
